// ===== rtl/rrc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rrc_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int REV_W       = 31;

    typedef enum logic [2:0] {
        OUT_INSIDE   = 3'd0,
        OUT_EXTENDED = 3'd1,
        OUT_APPENDED = 3'd2,
        OUT_DROPPED  = 3'd3,
        OUT_CLEARED  = 3'd4
    } t_outcome;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic             mode;
        logic [REV_W-1:0] revision;
        logic             descending;
    } t_in_item;

    typedef struct packed {
        t_outcome         outcome;
        logic [5:0]       entry_index;
        logic [REV_W-1:0] entry_first;
        logic [REV_W-1:0] entry_last;
        logic [6:0]       entry_total;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic scan;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic skip_scan;
        logic hit;
        logic scan_end;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

// ===== rtl/rrc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rrc_ctrl (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_in_valid,
    output logic            o_in_ready,
    input  rrc_pkg::t_status i_status,
    output rrc_pkg::t_cmd   o_cmd
);
    import rrc_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_status.skip_scan || i_status.hit || i_status.scan_end) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready   = 1'b0;
        o_cmd        = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
            end
            S_RESULT: begin
                o_cmd.finish = i_status.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/rrc_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rrc_datapath (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  rrc_pkg::t_in_item  i_in_item,
    input  rrc_pkg::t_cmd      i_cmd,
    output rrc_pkg::t_status   o_status,
    output logic               o_out_valid,
    input  wire                i_out_ready,
    output rrc_pkg::t_out_item o_out_item
);
    import rrc_pkg::*;

    localparam int WORD_W = 2 * REV_W;

    logic [WORD_W-1:0] mem [TABLE_DEPTH];

    t_in_item          r_item;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic [CNT_W-1:0]  r_rd_idx;
    logic [CNT_W-1:0]  r_cmp_idx;
    logic              r_rd_dv;
    logic [WORD_W-1:0] r_rd_data;

    logic              r_found;
    t_outcome          r_hit_kind;
    logic [IDX_W-1:0]  r_hit_idx;
    logic [REV_W-1:0]  r_hit_first;
    logic [REV_W-1:0]  r_hit_last;

    logic              r_out_valid;
    t_out_item         r_out;
    t_out_item         n_out;

    logic              w_rd_more;
    logic [REV_W-1:0]  w_f;
    logic [REV_W-1:0]  w_l;
    logic [REV_W-1:0]  w_lo;
    logic [REV_W-1:0]  w_hi;
    logic              w_desc;
    logic [REV_W:0]    w_rev_p1;
    logic [REV_W-1:0]  w_rev_m1;
    logic              w_inside;
    logic              w_below;
    logic              w_above;
    logic              w_hit;
    t_outcome          w_kind;
    logic [REV_W-1:0]  w_new_first;
    logic [REV_W-1:0]  w_new_last;

    logic              w_wr_en;
    logic [IDX_W-1:0]  w_wr_addr;
    logic [WORD_W-1:0] w_wr_data;

    assign w_rd_more = r_rd_idx < r_count;

    // entry compare against the registered read word
    always_comb begin
        w_f      = r_rd_data[WORD_W-1:REV_W];
        w_l      = r_rd_data[REV_W-1:0];
        w_rev_p1 = {1'b0, r_item.revision} + {{REV_W{1'b0}}, 1'b1};
        w_rev_m1 = r_item.revision - {{(REV_W-1){1'b0}}, 1'b1};
        if (w_f > w_l) begin
            w_lo   = w_l;
            w_hi   = w_f;
            w_desc = 1'b1;
        end else begin
            w_lo   = w_f;
            w_hi   = w_l;
            w_desc = (w_f == w_l) ? r_item.descending : 1'b0;
        end
        w_inside = (w_lo <= r_item.revision) && (r_item.revision <= w_hi);
        w_below  = ({1'b0, w_lo} == w_rev_p1);
        w_above  = (r_item.revision != '0) && (w_hi == w_rev_m1);
        w_hit    = w_inside || w_below || w_above;
        w_kind   = OUT_EXTENDED;
        if (w_inside) begin
            w_kind      = OUT_INSIDE;
            w_new_first = w_f;
            w_new_last  = w_l;
        end else if (w_below) begin
            w_new_first = w_desc ? w_hi : r_item.revision;
            w_new_last  = w_desc ? r_item.revision : w_hi;
        end else begin
            w_new_first = w_desc ? r_item.revision : w_lo;
            w_new_last  = w_desc ? w_lo : r_item.revision;
        end
    end

    assign o_status.skip_scan = r_item.mode || (r_count == '0);
    assign o_status.hit       = r_rd_dv && w_hit;
    assign o_status.scan_end  = r_rd_dv && ((r_cmp_idx + CNT_W'(1)) == r_count);
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    // result and write-back
    always_comb begin
        n_count   = r_count;
        n_out     = '0;
        w_wr_en   = 1'b0;
        w_wr_addr = r_count[IDX_W-1:0];
        w_wr_data = {r_item.revision, r_item.revision};
        if (r_item.mode) begin
            n_count       = '0;
            n_out.outcome = OUT_CLEARED;
        end else if (r_found) begin
            n_out.outcome     = r_hit_kind;
            n_out.entry_index = 6'(r_hit_idx);
            n_out.entry_first = r_hit_first;
            n_out.entry_last  = r_hit_last;
            w_wr_en           = (r_hit_kind == OUT_EXTENDED);
            w_wr_addr         = r_hit_idx;
            w_wr_data         = {r_hit_first, r_hit_last};
        end else if (r_count == CNT_W'(TABLE_DEPTH)) begin
            n_out.outcome = OUT_DROPPED;
        end else begin
            n_count           = r_count + CNT_W'(1);
            n_out.outcome     = OUT_APPENDED;
            n_out.entry_index = 6'(r_count[IDX_W-1:0]);
            n_out.entry_first = r_item.revision;
            n_out.entry_last  = r_item.revision;
            w_wr_en           = 1'b1;
        end
        n_out.entry_total = 7'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish && w_wr_en) begin
            mem[w_wr_addr] <= w_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan && w_rd_more) begin
            r_rd_data <= mem[r_rd_idx[IDX_W-1:0]];
            r_cmp_idx <= r_rd_idx;
        end
        if (i_cmd.load) begin
            r_item <= i_in_item;
        end
        if (i_cmd.scan && r_rd_dv && w_hit && !r_found) begin
            r_hit_kind  <= w_kind;
            r_hit_idx   <= r_cmp_idx[IDX_W-1:0];
            r_hit_first <= w_new_first;
            r_hit_last  <= w_new_last;
        end
        if (i_cmd.finish) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rd_idx    <= '0;
            r_rd_dv     <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_rd_idx <= '0;
                r_rd_dv  <= 1'b0;
                r_found  <= 1'b0;
            end else if (i_cmd.scan) begin
                r_rd_dv <= w_rd_more;
                if (w_rd_more) begin
                    r_rd_idx <= r_rd_idx + CNT_W'(1);
                end
                if (r_rd_dv && w_hit) begin
                    r_found <= 1'b1;
                end
            end
            if (i_cmd.finish) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_cmp_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.scan && r_rd_dv) |-> (r_cmp_idx < r_count))
        else $error("compare of an entry beyond the held count");

    a_finish_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> (!r_out_valid || i_out_ready))
        else $error("result overwrites a pending transfer");

    a_finish_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> r_out_valid)
        else $error("finished result not presented");

endmodule

`default_nettype wire

// ===== rtl/revision_range_coalescer.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Revision range table with insert-and-coalesce. One item at a time: an add
// item scans the held entries through a single memory read port, one entry
// per cycle, and stops at the first entry that contains or touches the
// revision. A touched entry is extended in the write-back, an entry that
// contains the revision is left as it is, and with no hit a new entry is
// appended, or the item is dropped when the 64-entry table is full. A clear
// item, or an add to an empty table, skips the scan; a clear empties the
// table. The result sits in an output register, so the next item is taken
// while it waits. No clearing pass follows reset.
module revision_range_coalescer (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_ready,
    input  rrc_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  wire                i_out_ready,
    output rrc_pkg::t_out_item o_out_item
);
    import rrc_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    rrc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    rrc_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire
